@@ design/cdft_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants for the contour DFT coefficient block.
// Also holds the elaboration-time sine and cosine series used to build the twiddle table.
package cdft_pkg;

    localparam int COORD_W = 12;
    localparam int INDEX_W = 8;
    localparam int COEF_W  = 25;
    localparam int COUNT_W = 9;
    localparam int TW_W    = 16;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd150;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint ONE_Q30    = 64'sd1073741824;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load_we;
        logic start;
        logic issue;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic req_oor;
        logic last_k;
        logic drained;
        logic out_busy;
    } sts_t;

    function automatic longint q30_mul(longint a, longint b);
        longint unsigned p;
        p = longint'(longint'(a) * longint'(b));
        return longint'(p >> 30);
    endfunction

    // Long division of a non-negative series term by a positive divisor, truncating.
    function automatic longint series_div(longint n, longint d);
        longint unsigned num;
        longint unsigned den;
        longint unsigned quo;
        longint unsigned rem;
        num = n;
        den = d;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return longint'(quo);
    endfunction

    function automatic logic signed [TW_W-1:0] q30_to_q15(longint v);
        longint r;
        longint t;
        t = (v < 0) ? 64'sd0 : v;
        r = (t + 64'sd16384) >>> 15;
        if (r > 64'sd32767)
        begin
            r = 64'sd32767;
        end
        return TW_W'(r);
    endfunction

    // Taylor series for the first quadrant, angle in Q30.
    function automatic logic signed [TW_W-1:0] tw_sin(longint a);
        longint a2;
        longint term;
        longint acc;
        longint d;
        a2   = q30_mul(a, a);
        term = a;
        acc  = a;
        for (int i = 1; i < 16; i++)
        begin
            d    = longint'((2 * i) * (2 * i + 1));
            term = series_div(q30_mul(term, a2), d);
            acc  = ((i % 2) == 1) ? acc - term : acc + term;
        end
        return q30_to_q15(acc);
    endfunction

    function automatic logic signed [TW_W-1:0] tw_cos(longint a);
        longint a2;
        longint term;
        longint acc;
        longint d;
        a2   = q30_mul(a, a);
        term = ONE_Q30;
        acc  = ONE_Q30;
        for (int i = 1; i < 16; i++)
        begin
            d    = longint'((2 * i - 1) * (2 * i));
            term = series_div(q30_mul(term, a2), d);
            acc  = ((i % 2) == 1) ? acc - term : acc + term;
        end
        return q30_to_q15(acc);
    endfunction

endpackage

@@ design/cdft_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cdft_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/cdft_rom.sv @@
`timescale 1ns / 1ps
// Twiddle table of cosine and sine in Q1.15 with a registered read.
// The table is built at elaboration from the series functions in cdft_pkg.
module cdft_rom #(
    parameter int POINTS = 256
) (
    input  logic                                clk,
    input  logic [$clog2(POINTS)-1:0]           addr,
    output logic signed [cdft_pkg::TW_W-1:0]    cos_val,
    output logic signed [cdft_pkg::TW_W-1:0]    sin_val
);
    import cdft_pkg::*;

    localparam int QUARTER = POINTS / 4;

    logic signed [TW_W-1:0] cos_tab [POINTS];
    logic signed [TW_W-1:0] sin_tab [POINTS];
    logic signed [TW_W-1:0] cos_reg;
    logic signed [TW_W-1:0] sin_reg;

    for (genvar m = 0; m < POINTS; m++)
    begin : g_tab
        localparam int     QUAD = (m / QUARTER) % 4;
        localparam int     REM  = m % QUARTER;
        localparam longint ANG  = (longint'(REM) * TWO_PI_Q30) / POINTS;
        localparam logic signed [TW_W-1:0] S_Q = tw_sin(ANG);
        localparam logic signed [TW_W-1:0] C_Q = tw_cos(ANG);
        localparam logic signed [TW_W-1:0] COS_M =
            (QUAD == 0) ? C_Q : (QUAD == 1) ? -S_Q : (QUAD == 2) ? -C_Q : S_Q;
        localparam logic signed [TW_W-1:0] SIN_M =
            (QUAD == 0) ? S_Q : (QUAD == 1) ? C_Q : (QUAD == 2) ? -S_Q : -C_Q;
        assign cos_tab[m] = COS_M;
        assign sin_tab[m] = SIN_M;
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= cos_tab[addr];
        sin_reg <= sin_tab[addr];
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

@@ design/cdft_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine: accepts transactions and sequences the accumulation.
// Depends on cdft_pkg for the state, command and status types.
module cdft_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_op,
    output logic           in_ready,
    input  cdft_pkg::sts_t sts,
    output cdft_pkg::cmd_t cmd
);
    import cdft_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (in_op == OP_LOAD))
                begin
                    cmd.load_we = 1'b1;
                end
                else if (in_valid && (in_op == OP_REQUEST))
                begin
                    cmd.start  = 1'b1;
                    state_next = sts.req_oor ? ST_RESULT : ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                cmd.issue = 1'b1;
                if (sts.last_k)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.drained)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/cdft_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: point store, twiddle table, complex multiply-accumulate, rounding and result register.
// Depends on cdft_pkg, cdft_ram and cdft_rom.
module cdft_datapath #(
    parameter int POINTS = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cdft_pkg::cmd_t                        cmd,
    output cdft_pkg::sts_t                        sts,
    input  logic [cdft_pkg::INDEX_W-1:0]          in_index,
    input  logic signed [cdft_pkg::COORD_W-1:0]   in_x,
    input  logic signed [cdft_pkg::COORD_W-1:0]   in_y,
    input  logic                                  cfg_valid,
    input  logic [cdft_pkg::COUNT_W-1:0]          cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [cdft_pkg::INDEX_W-1:0]          out_index,
    output logic signed [cdft_pkg::COEF_W-1:0]    out_real,
    output logic signed [cdft_pkg::COEF_W-1:0]    out_imag,
    output logic                                  out_oor
);
    import cdft_pkg::*;

    localparam int AW    = $clog2(POINTS);
    localparam int PR_W  = COORD_W + TW_W;
    localparam int ACC_W = PR_W + 1 + AW;
    localparam int SH    = AW + 3;
    localparam int SH_W  = ACC_W + 1 - SH;
    localparam logic signed [ACC_W:0] RND = (ACC_W + 1)'(longint'(1) << (AW + 2));
    localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((longint'(1) << (COEF_W - 1)) - 1);
    localparam logic signed [SH_W-1:0] SAT_LO = -SAT_HI - SH_W'(1);

    logic [COUNT_W-1:0] count_reg;

    logic [INDEX_W-1:0] idx_reg;
    logic               oor_reg;
    logic [AW-1:0]      k_reg;
    logic [AW-1:0]      m_reg;
    logic [AW-1:0]      u_tw;

    logic                        rd_v_reg;
    logic                        prod_v_reg;
    logic [2*COORD_W-1:0]        pt_rdata;
    logic signed [COORD_W-1:0]   pt_x;
    logic signed [COORD_W-1:0]   pt_y;
    logic signed [TW_W-1:0]      tw_c;
    logic signed [TW_W-1:0]      tw_s;
    logic signed [PR_W-1:0]      p_xc_reg;
    logic signed [PR_W-1:0]      p_ys_reg;
    logic signed [PR_W-1:0]      p_yc_reg;
    logic signed [PR_W-1:0]      p_xs_reg;
    logic signed [ACC_W-1:0]     acc_re_reg;
    logic signed [ACC_W-1:0]     acc_im_reg;

    logic signed [ACC_W:0]       re_rnd;
    logic signed [ACC_W:0]       im_rnd;
    logic signed [SH_W-1:0]      re_sh;
    logic signed [SH_W-1:0]      im_sh;

    logic                        out_valid_reg;
    logic [INDEX_W-1:0]          out_index_reg;
    logic signed [COEF_W-1:0]    out_real_reg;
    logic signed [COEF_W-1:0]    out_imag_reg;
    logic                        out_oor_reg;

    logic                        load_ok;

    function automatic logic signed [COEF_W-1:0] sat_coef(logic signed [SH_W-1:0] v);
        logic signed [SH_W-1:0] t;
        t = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        return COEF_W'(t);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            count_reg <= cfg_data;
        end
    end

    assign sts.req_oor = ({1'b0, in_index} >= count_reg);
    assign load_ok     = (32'(in_index) < POINTS);

    cdft_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (POINTS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load_we && load_ok),
        .waddr (AW'(in_index)),
        .wdata ({in_y, in_x}),
        .raddr (k_reg),
        .rdata (pt_rdata)
    );

    cdft_rom #(
        .POINTS (POINTS)
    ) u_rom (
        .clk     (clk),
        .addr    (m_reg),
        .cos_val (tw_c),
        .sin_val (tw_s)
    );

    assign pt_x = pt_rdata[COORD_W-1:0];
    assign pt_y = pt_rdata[2*COORD_W-1:COORD_W];
    assign u_tw = AW'(idx_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            idx_reg <= in_index;
            oor_reg <= sts.req_oor;
            k_reg   <= '0;
            m_reg   <= '0;
        end
        else if (cmd.issue)
        begin
            k_reg <= k_reg + AW'(1);
            m_reg <= m_reg + u_tw;
        end
    end

    assign sts.last_k = (k_reg == AW'(POINTS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg   <= cmd.issue;
            prod_v_reg <= rd_v_reg;
        end
    end

    assign sts.drained = !rd_v_reg && !prod_v_reg;

    always_ff @(posedge clk)
    begin
        p_xc_reg <= pt_x * tw_c;
        p_ys_reg <= pt_y * tw_s;
        p_yc_reg <= pt_y * tw_c;
        p_xs_reg <= pt_x * tw_s;
        if (cmd.start)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(p_xc_reg) + ACC_W'(p_ys_reg);
            acc_im_reg <= acc_im_reg + ACC_W'(p_yc_reg) - ACC_W'(p_xs_reg);
        end
    end

    // Division by 8*POINTS, rounded to nearest with ties toward plus infinity.
    assign re_rnd = (ACC_W + 1)'(acc_re_reg) + RND;
    assign im_rnd = (ACC_W + 1)'(acc_im_reg) + RND;
    assign re_sh  = re_rnd[ACC_W:SH];
    assign im_sh  = im_rnd[ACC_W:SH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_index_reg <= idx_reg;
            out_oor_reg   <= oor_reg;
            out_real_reg  <= oor_reg ? '0 : sat_coef(re_sh);
            out_imag_reg  <= oor_reg ? '0 : sat_coef(im_sh);
        end
    end

    assign sts.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_real  = out_real_reg;
    assign out_imag  = out_imag_reg;
    assign out_oor   = out_oor_reg;

endmodule

@@ design/contour_dft_coefficients.sv @@
`timescale 1ns / 1ps
// Top level of the contour DFT coefficient block: stream ports around controller and datapath.
// Depends on cdft_pkg, cdft_ctrl and cdft_datapath.
//
//   Channel   Direction  Signals                          Contents
//   s_axis    in         tvalid tready tdata[31:0] tuser  load point or request descriptor
//   m_axis    out        tvalid tready tdata[63:0] tuser  descriptor result
//   cfg       in         valid ready data[8:0]            coefficient count register
//
// A load transaction returns nothing.
// A request in range runs one complex multiply-accumulate per stored point through the point
// store read port before the next input is taken; a request out of range skips the accumulation.
// Reset is asynchronous and leaves the count at 150.
// A result waiting on m_axis stalls only the completion of the following request.
module contour_dft_coefficients #(
    parameter int POINTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // index[7:0], point_x[19:8], point_y[31:20]
    input  logic        s_axis_tuser,   // op[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // coefficient_index[7:0], coeff_real[32:8],
                                        // coeff_imag[57:33], zero[63:58]
    output logic        m_axis_tuser,   // out_of_range[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);
    import cdft_pkg::*;

    cmd_t cmd;
    sts_t sts;

    logic [INDEX_W-1:0]        out_index;
    logic signed [COEF_W-1:0]  out_real;
    logic signed [COEF_W-1:0]  out_imag;

    assign cfg_ready = 1'b1;

    cdft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cdft_datapath #(
        .POINTS (POINTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_index  (s_axis_tdata[7:0]),
        .in_x      (s_axis_tdata[19:8]),
        .in_y      (s_axis_tdata[31:20]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_index (out_index),
        .out_real  (out_real),
        .out_imag  (out_imag),
        .out_oor   (m_axis_tuser)
    );

    assign m_axis_tdata = {6'b0, out_imag, out_real, out_index};

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for contour_dft_coefficients: a directed table, then random
// load and request traffic checked against an in-bench descriptor predictor.
// Depends on cdft_pkg and the contour_dft_coefficients RTL only.
module testbench;

    import cdft_pkg::*;

    localparam int FIGURE_POINTS = 256;
    localparam int QUARTER_POINTS = FIGURE_POINTS / 4;
    localparam int DESCALE_SHIFT = $clog2(8 * FIGURE_POINTS);
    localparam longint ANGLE_TURN_Q30 = 64'sd6746518852;
    localparam longint UNIT_Q30 = 64'sd1073741824;
    localparam longint COEF_MAX = 64'sd16777215;
    localparam longint COEF_MIN = -64'sd16777216;
    localparam int CONFIG_SETTLE = 8;
    localparam int TAIL_CYCLES = FIGURE_POINTS + 16;
    localparam int MAX_PRINTED = 40;
    localparam realtime RUN_LIMIT = 4000000.0;

    typedef struct packed {
        logic [7:0]         index;
        logic signed [24:0] re;
        logic signed [24:0] im;
        logic               out_of_range;
    } descriptor_t;

    typedef struct packed {
        bit                 is_config;
        logic               op;
        logic [7:0]         index;
        logic signed [11:0] px;
        logic signed [11:0] py;
        logic [8:0]         count;
        bit                 typed;
        descriptor_t        want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // index[7:0], point_x[19:8], point_y[31:20]
    logic        s_axis_tuser;   // op[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // coefficient_index[7:0], coeff_real[32:8], coeff_imag[57:33]
    logic        m_axis_tuser;   // out_of_range[0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;

    bit                 quiet_tail;
    int                 mismatches;
    logic [8:0]         active_count;
    logic signed [11:0] contour_x [FIGURE_POINTS];
    logic signed [11:0] contour_y [FIGURE_POINTS];
    int                 twiddle_cos [FIGURE_POINTS];
    int                 twiddle_sin [FIGURE_POINTS];
    descriptor_t        descriptors_due [$];

    contour_dft_coefficients #(
        .POINTS(FIGURE_POINTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint q30_product(longint a, longint b);
        longint unsigned ua;
        longint unsigned ub;
        ua = a;
        ub = b;
        return longint'((ua * ub) >> 30);
    endfunction

    function automatic int round_q15(longint v);
        longint r;
        r = (v < 0) ? 64'sd0 : v;
        r = (r + 64'sd16384) >>> 15;
        if (r > 64'sd32767)
        begin
            r = 64'sd32767;
        end
        return int'(r);
    endfunction

    function automatic void first_quadrant(input longint angle, output longint s,
                                           output longint c);
        longint a2;
        longint sterm;
        longint cterm;
        a2    = q30_product(angle, angle);
        sterm = angle;
        cterm = UNIT_Q30;
        s     = angle;
        c     = UNIT_Q30;
        for (int i = 1; i < 16; i++)
        begin
            sterm = q30_product(sterm, a2) / longint'((2 * i) * (2 * i + 1));
            cterm = q30_product(cterm, a2) / longint'((2 * i - 1) * (2 * i));
            if ((i % 2) == 1)
            begin
                s = s - sterm;
                c = c - cterm;
            end
            else
            begin
                s = s + sterm;
                c = c + cterm;
            end
        end
    endfunction

    function automatic void build_twiddles();
        longint angle;
        longint s64;
        longint c64;
        int     s;
        int     c;
        int     quadrant;
        for (int m = 0; m < FIGURE_POINTS; m++)
        begin
            quadrant = (m / QUARTER_POINTS) % 4;
            angle = (longint'(m % QUARTER_POINTS) * ANGLE_TURN_Q30) / FIGURE_POINTS;
            first_quadrant(angle, s64, c64);
            s = round_q15(s64);
            c = round_q15(c64);
            case (quadrant)
                0:
                begin
                    twiddle_cos[m] = c;
                    twiddle_sin[m] = s;
                end
                1:
                begin
                    twiddle_cos[m] = -s;
                    twiddle_sin[m] = c;
                end
                2:
                begin
                    twiddle_cos[m] = -c;
                    twiddle_sin[m] = -s;
                end
                default:
                begin
                    twiddle_cos[m] = s;
                    twiddle_sin[m] = -c;
                end
            endcase
        end
    endfunction

    function automatic logic signed [24:0] scale_q12(longint acc);
        longint v;
        v = (acc + (64'sd1 <<< (DESCALE_SHIFT - 1))) >>> DESCALE_SHIFT;
        if (v > COEF_MAX)
        begin
            v = COEF_MAX;
        end
        else if (v < COEF_MIN)
        begin
            v = COEF_MIN;
        end
        return 25'(v);
    endfunction

    function automatic descriptor_t predict_descriptor(logic [7:0] u);
        descriptor_t d;
        longint      re_sum;
        longint      im_sum;
        longint      x;
        longint      y;
        longint      c;
        longint      s;
        int          m;
        d.index        = u;
        d.re           = '0;
        d.im           = '0;
        d.out_of_range = 1'b1;
        if ({1'b0, u} >= active_count)
        begin
            return d;
        end
        re_sum = 0;
        im_sum = 0;
        for (int k = 0; k < FIGURE_POINTS; k++)
        begin
            m = (k * int'(u)) % FIGURE_POINTS;
            x = longint'(contour_x[k]);
            y = longint'(contour_y[k]);
            c = longint'(twiddle_cos[m]);
            s = longint'(twiddle_sin[m]);
            re_sum = re_sum + x * c + y * s;
            im_sum = im_sum + y * c - x * s;
        end
        d.re           = scale_q12(re_sum);
        d.im           = scale_q12(im_sum);
        d.out_of_range = 1'b0;
        return d;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
        begin
            $display("%0t ns: %s", $realtime, what);
        end
    endtask

    task automatic compare_descriptor(descriptor_t got);
        descriptor_t want;
        if (descriptors_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected descriptor for index %0d", got.index));
            return;
        end
        want = descriptors_due.pop_front();
        if (got.index !== want.index)
        begin
            report_mismatch($sformatf("coefficient_index got %0d expected %0d",
                                      got.index, want.index));
        end
        if (got.re !== want.re)
        begin
            report_mismatch($sformatf("coeff_real of index %0d got %0d expected %0d",
                                      want.index, longint'(got.re), longint'(want.re)));
        end
        if (got.im !== want.im)
        begin
            report_mismatch($sformatf("coeff_imag of index %0d got %0d expected %0d",
                                      want.index, longint'(got.im), longint'(want.im)));
        end
        if (got.out_of_range !== want.out_of_range)
        begin
            report_mismatch($sformatf("out_of_range of index %0d got %0b expected %0b",
                                      want.index, got.out_of_range, want.out_of_range));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            compare_descriptor('{index: m_axis_tdata[7:0], re: m_axis_tdata[32:8],
                                 im: m_axis_tdata[57:33], out_of_range: m_axis_tuser});
        end
    end

    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    task automatic pause_sender(int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results(int settle);
        s_axis_tvalid <= 1'b0;
        while (descriptors_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_count(logic [8:0] value);
        drain_results(CONFIG_SETTLE);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        active_count = value;
    endtask

    task automatic send_item(logic op, logic [7:0] index, logic signed [11:0] px,
                             logic signed [11:0] py, bit typed, descriptor_t want);
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            pause_sender($urandom_range(1, 5));
        end
        s_axis_tdata  <= {py, px, index};
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        if (op == OP_LOAD)
        begin
            contour_x[index] = px;
            contour_y[index] = py;
        end
        else
        begin
            descriptors_due.push_back(typed ? want : predict_descriptor(index));
        end
    endtask

    function automatic logic signed [11:0] pick_coord();
        case ($urandom_range(0, 15))
            0: return -12'sd2048;
            1: return 12'sd2047;
            2: return 12'sd0;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic stim_row_t load_row(logic [7:0] index, logic signed [11:0] px,
                                           logic signed [11:0] py);
        stim_row_t r;
        r       = '0;
        r.op    = OP_LOAD;
        r.index = index;
        r.px    = px;
        r.py    = py;
        return r;
    endfunction

    function automatic stim_row_t request_row(logic [7:0] index);
        stim_row_t r;
        r       = '0;
        r.op    = OP_REQUEST;
        r.index = index;
        r.px    = 12'hFFF;
        r.py    = 12'hFFF;
        return r;
    endfunction

    function automatic stim_row_t flagged_row(logic [7:0] index);
        stim_row_t r;
        r       = request_row(index);
        r.typed = 1'b1;
        r.want  = '{index: index, re: 25'sd0, im: 25'sd0, out_of_range: 1'b1};
        return r;
    endfunction

    function automatic stim_row_t config_row(logic [8:0] count);
        stim_row_t r;
        r           = '0;
        r.is_config = 1'b1;
        r.count     = count;
        return r;
    endfunction

    task automatic random_traffic(int items);
        logic [7:0] index;
        for (int n = 0; n < items; n++)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                drain_results(1);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                send_item(OP_LOAD, 8'($urandom_range(0, 255)), pick_coord(), pick_coord(),
                          1'b0, '0);
            end
            else
            begin
                if (active_count != 0 && $urandom_range(0, 3) != 0)
                begin
                    index = 8'($urandom_range(0, (active_count > 256) ? 255 : active_count - 1));
                end
                else
                begin
                    index = 8'($urandom_range(0, 255));
                end
                send_item(OP_REQUEST, index, 12'($urandom_range(0, 4095)),
                          12'($urandom_range(0, 4095)), 1'b0, '0);
            end
        end
    endtask

    initial
    begin
        stim_row_t rows [$];
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_LOAD;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        quiet_tail   = 1'b0;
        mismatches   = 0;
        active_count = COUNT_RESET;
        build_twiddles();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Every point is written before the first request.
        for (int k = 0; k < FIGURE_POINTS; k++)
        begin
            send_item(OP_LOAD, 8'(k), pick_coord(), pick_coord(), 1'b0, '0);
        end

        rows.push_back(flagged_row(8'd255));
        rows.push_back(flagged_row(8'd150));
        rows.push_back(request_row(8'd149));
        rows.push_back(request_row(8'd0));
        rows.push_back(load_row(8'd0, 12'sd2047, 12'sd2047));
        rows.push_back(load_row(8'd1, -12'sd2048, -12'sd2048));
        rows.push_back(load_row(8'd128, 12'sd2047, -12'sd2048));
        rows.push_back(load_row(8'd255, -12'sd2048, 12'sd2047));
        rows.push_back(load_row(8'd64, 12'sd0, 12'sd0));
        rows.push_back(request_row(8'd0));
        rows.push_back(request_row(8'd1));
        rows.push_back(request_row(8'd64));
        rows.push_back(request_row(8'd128));
        rows.push_back(config_row(9'd0));
        rows.push_back(flagged_row(8'd0));
        rows.push_back(flagged_row(8'd1));
        rows.push_back(config_row(9'd256));
        rows.push_back(request_row(8'd255));
        rows.push_back(request_row(8'd192));
        rows.push_back(config_row(9'd1));
        rows.push_back(request_row(8'd0));
        rows.push_back(flagged_row(8'd1));
        rows.push_back(config_row(9'd255));
        rows.push_back(request_row(8'd254));
        rows.push_back(flagged_row(8'd255));

        foreach (rows[i])
        begin
            if (rows[i].is_config)
            begin
                write_count(rows[i].count);
            end
            else
            begin
                send_item(rows[i].op, rows[i].index, rows[i].px, rows[i].py,
                          rows[i].typed, rows[i].want);
            end
        end

        write_count(9'd256);
        random_traffic(40);
        write_count(9'd1);
        random_traffic(20);
        write_count(9'($urandom_range(2, 254)));
        random_traffic(50);
        write_count(COUNT_RESET);
        quiet_tail = 1'b1;
        random_traffic(60);

        drain_results(TAIL_CYCLES);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
